// ===== hdl/shrc_pkg.sv =====
// ----------------------------------------------------------------------------
// shrc_pkg
// Shared types, constants and the coil table of the half-step ramp controller.
// ----------------------------------------------------------------------------
package shrc_pkg;

  localparam int KIND_W   = 2;
  localparam int RATE_W   = 13;
  localparam int POS_W    = 24;
  localparam int PERIOD_W = 16;
  localparam int COIL_W   = 4;
  localparam int ACCEL_W  = 15;
  localparam int MAXS_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  localparam int DVD_W  = 32;
  localparam int DSR_W  = 20;
  localparam int QUO_W  = 20;
  localparam int ITER_W = 6;

  // 1000000 = 64 * 15625; floor(x / 15625) = (x * INC_RECIP) >> 40 for x < 2^26
  localparam int PROD_W   = ACCEL_W + PERIOD_W + 1;
  localparam int SCALE_SH = 6;
  localparam int RECIP_W  = 27;
  localparam int RECIP_SH = 40;
  localparam int MUL_W    = PROD_W - SCALE_SH + RECIP_W;

  localparam logic [KIND_W-1:0] KIND_PERIOD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd2;

  localparam logic [DSR_W-1:0]    TICKS_PER_SEC = 20'd1000000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'hFFFF;
  localparam logic [ITER_W-1:0]   ITER_PER      = 6'd20;
  localparam logic [DVD_W-1:0]    PER_DIVIDEND  = 32'd4096000000;
  localparam logic [RECIP_W-1:0]  INC_RECIP     = 27'd70368745;

  typedef struct packed {
    logic accept;
    logic start_inc;
    logic load_inc;
    logic ramp;
    logic start_per;
    logic set_idle;
    logic set_period;
    logic emit;
  } shrc_cmd_t;

  typedef struct packed {
    logic need_ramp;
    logic div_done;
    logic rate_zero;
  } shrc_status_t;

  function automatic logic [COIL_W-1:0] coil_of(input logic [2:0] ph);
    logic [COIL_W-1:0] c;
    case (ph)
      3'd0: c = 4'b0001;
      3'd1: c = 4'b0011;
      3'd2: c = 4'b0010;
      3'd3: c = 4'b0110;
      3'd4: c = 4'b0100;
      3'd5: c = 4'b1100;
      3'd6: c = 4'b1000;
      3'd7: c = 4'b1001;
      default: c = 4'b0001;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/shrc_in_if.sv =====
// ----------------------------------------------------------------------------
// shrc_in_if
// Command item channel: kind and signed target rate.
// ----------------------------------------------------------------------------
interface shrc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [shrc_pkg::KIND_W-1:0]            kind;
  logic signed [shrc_pkg::RATE_W-1:0]     target_rate;

  modport source (output valid, kind, target_rate, input ready);
  modport sink   (input valid, kind, target_rate, output ready);
endinterface

// ===== hdl/shrc_out_if.sv =====
// ----------------------------------------------------------------------------
// shrc_out_if
// Result item channel: coil drive, timer period and motion status.
// ----------------------------------------------------------------------------
interface shrc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [shrc_pkg::COIL_W-1:0]            coil_pattern;
  logic                                   step_taken;
  logic [shrc_pkg::PERIOD_W-1:0]          tick_period;
  logic                                   running;
  logic signed [shrc_pkg::POS_W-1:0]      position;
  logic signed [shrc_pkg::RATE_W-1:0]     current_rate;
  logic                                   limit_reached;

  modport source (output valid, coil_pattern, step_taken, tick_period, running,
                  position, current_rate, limit_reached, input ready);
  modport sink   (input valid, coil_pattern, step_taken, tick_period, running,
                  position, current_rate, limit_reached, output ready);
endinterface

// ===== hdl/stepper_half_step_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_ramp_controller
// Half-step stepper drive with trapezoidal rate ramp, one result per item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        kind, target_rate
//  out_chan  out  valid/ready        coil_pattern .. limit_reached
//  cfg_*     in   cfg_we, no ready   cfg_index, cfg_wdata
//
//  Items without a ramp pass through accept and emit.
//  A ramp step runs accept, increment product, ramp, divide launch, the
//  period quotient on the radix-2 divider, load, emit.
//  A ramp that lands on zero rate skips the divide.
//  Reset is synchronous on rst_n and restores the idle motor state.
//  A result waits in the output register; the next item is taken meanwhile
//  and holds in the emit step until the output register frees.
// ----------------------------------------------------------------------------
module stepper_half_step_ramp_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  shrc_in_if.sink                           in_chan,
  shrc_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [shrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shrc_pkg::CFG_W-1:0]        cfg_wdata
);
  import shrc_pkg::*;

  shrc_cmd_t    cmd;
  shrc_status_t status;

  shrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  shrc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_kind     (in_chan.kind),
    .in_target   (in_chan.target_rate),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_coil    (out_chan.coil_pattern),
    .out_step    (out_chan.step_taken),
    .out_period  (out_chan.tick_period),
    .out_running (out_chan.running),
    .out_pos     (out_chan.position),
    .out_rate    (out_chan.current_rate),
    .out_limit   (out_chan.limit_reached)
  );

endmodule

// ===== hdl/shrc_div.sv =====
// ----------------------------------------------------------------------------
// shrc_div
// Restoring radix-2 divider, one quotient bit per cycle, run length per start.
// ----------------------------------------------------------------------------
module shrc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [shrc_pkg::DVD_W-1:0]      dividend,
  input  logic [shrc_pkg::DSR_W-1:0]      divisor,
  input  logic [shrc_pkg::ITER_W-1:0]     iters,
  output logic [shrc_pkg::QUO_W-1:0]      quotient,
  output logic                            done
);
  import shrc_pkg::*;

  logic [DVD_W-1:0]  acc_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem_r, acc_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fits    = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign quotient = acc_r[QUO_W-1:0];
  assign done     = done_r;

endmodule

// ===== hdl/shrc_datapath.sv =====
// ----------------------------------------------------------------------------
// shrc_datapath
// Motor state, configuration registers, ramp arithmetic and result register.
// ----------------------------------------------------------------------------
module shrc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  shrc_pkg::shrc_cmd_t                cmd,
  output shrc_pkg::shrc_status_t             status,
  input  logic [shrc_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [shrc_pkg::RATE_W-1:0] in_target,
  input  logic                               cfg_we,
  input  logic [shrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [shrc_pkg::CFG_W-1:0]         cfg_wdata,
  output logic [shrc_pkg::COIL_W-1:0]        out_coil,
  output logic                               out_step,
  output logic [shrc_pkg::PERIOD_W-1:0]      out_period,
  output logic                               out_running,
  output logic signed [shrc_pkg::POS_W-1:0]  out_pos,
  output logic signed [shrc_pkg::RATE_W-1:0] out_rate,
  output logic                               out_limit
);
  import shrc_pkg::*;

  logic [ACCEL_W-1:0]       accel_r;
  logic [MAXS_W-1:0]        maxs_r;
  logic                     invert_r;

  logic [2:0]               phase_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [RATE_W-1:0] rate_now_r;
  logic signed [RATE_W-1:0] rate_goal_r;
  logic [PERIOD_W-1:0]      period_r;
  logic                     active_r;
  logic                     step_r;
  logic                     limit_r;

  logic [COIL_W-1:0]        o_coil_r;
  logic                     o_step_r;
  logic [PERIOD_W-1:0]      o_period_r;
  logic                     o_running_r;
  logic [POS_W-1:0]         o_pos_r;
  logic [RATE_W-1:0]        o_rate_r;
  logic                     o_limit_r;

  logic [PROD_W-1:0]        prod_r;
  logic [RATE_W-1:0]        inc_q_r;

  logic [POS_W-1:0]         pos_mag;
  logic                     limit_hit;
  logic [RATE_W-1:0]        tgt_neg;
  logic [RATE_W-1:0]        tgt_eff;
  logic [QUO_W-1:0]         quo;
  logic [MUL_W-1:0]         inc_mul;
  logic [RATE_W-1:0]        inc;
  logic [RATE_W:0]          diff;
  logic [RATE_W:0]          diff_mag;
  logic [RATE_W-1:0]        rate_ramped;
  logic [RATE_W-1:0]        rate_mag;
  logic [QUO_W-1:0]         quo_m1;
  logic [PERIOD_W-1:0]      period_sat;
  logic [PROD_W-1:0]        product;
  logic                     div_start;
  logic [DVD_W-1:0]         div_dvd;
  logic [DSR_W-1:0]         div_dsr;
  logic [ITER_W-1:0]        div_iters;
  logic                     div_done;

  assign pos_mag   = pos_r[POS_W-1] ? (~pos_r + 1'b1) : pos_r;
  assign limit_hit = (maxs_r != '0) && (pos_mag >= {{(POS_W-MAXS_W){1'b0}}, maxs_r});

  assign tgt_neg = ~in_target + 1'b1;
  assign tgt_eff = !invert_r ? in_target :
                   (in_target == 13'h1000) ? 13'h0FFF : tgt_neg;

  assign inc_mul     = prod_r[PROD_W-1:SCALE_SH] * INC_RECIP;
  assign inc         = inc_q_r + 1'b1;
  assign diff        = {rate_goal_r[RATE_W-1], rate_goal_r} - {rate_now_r[RATE_W-1], rate_now_r};
  assign diff_mag    = diff[RATE_W] ? (~diff + 1'b1) : diff;
  assign rate_ramped = (diff_mag < {1'b0, inc}) ? rate_goal_r :
                       !diff[RATE_W] ? (rate_now_r + inc) : (rate_now_r - inc);

  assign rate_mag   = rate_now_r[RATE_W-1] ? (~rate_now_r + 1'b1) : rate_now_r;
  assign quo_m1     = quo - 1'b1;
  assign period_sat = (quo_m1 > {{(QUO_W-PERIOD_W){1'b0}}, PERIOD_MAX}) ? PERIOD_MAX
                      : quo_m1[PERIOD_W-1:0];

  assign product   = accel_r * ({1'b0, period_r} + 1'b1);
  assign div_start = cmd.start_per;
  assign div_dvd   = PER_DIVIDEND;
  assign div_dsr   = {{(DSR_W-RATE_W){1'b0}}, rate_mag};
  assign div_iters = ITER_PER;

  shrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .iters    (div_iters),
    .quotient (quo),
    .done     (div_done)
  );

  assign status.need_ramp = (in_kind == KIND_PERIOD) && active_r && !limit_hit &&
                            (rate_now_r != rate_goal_r);
  assign status.div_done  = div_done;
  assign status.rate_zero = (rate_now_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= '0;
      maxs_r   <= '0;
      invert_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL:  accel_r  <= cfg_wdata[ACCEL_W-1:0];
        REG_MAXS:   maxs_r   <= cfg_wdata[MAXS_W-1:0];
        REG_INVERT: invert_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_inc) begin
      prod_r <= product;
    end
    if (cmd.load_inc) begin
      inc_q_r <= inc_mul[MUL_W-1:RECIP_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pos_r       <= '0;
      rate_now_r  <= '0;
      rate_goal_r <= '0;
      period_r    <= PERIOD_MAX;
      active_r    <= 1'b0;
      step_r      <= 1'b0;
      limit_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        step_r  <= 1'b0;
        limit_r <= 1'b0;
        case (in_kind)
          KIND_PERIOD: begin
            if (active_r) begin
              if (limit_hit) begin
                rate_goal_r <= '0;
                rate_now_r  <= '0;
                pos_r       <= '0;
                active_r    <= 1'b0;
                period_r    <= PERIOD_MAX;
                limit_r     <= 1'b1;
              end else if (rate_now_r > 0) begin
                phase_r <= phase_r + 1'b1;
                pos_r   <= pos_r + 1'b1;
                step_r  <= 1'b1;
              end else if (rate_now_r < 0) begin
                phase_r <= phase_r - 1'b1;
                pos_r   <= pos_r - 1'b1;
                step_r  <= 1'b1;
              end
            end
          end
          KIND_TARGET: begin
            rate_goal_r <= tgt_eff;
            active_r    <= 1'b1;
          end
          KIND_STOP: begin
            rate_goal_r <= '0;
            rate_now_r  <= '0;
            pos_r       <= '0;
            active_r    <= 1'b0;
            period_r    <= PERIOD_MAX;
          end
          default: ;
        endcase
      end
      if (cmd.ramp) begin
        rate_now_r <= rate_ramped;
      end
      if (cmd.set_idle) begin
        period_r <= PERIOD_MAX;
        active_r <= 1'b0;
      end
      if (cmd.set_period) begin
        period_r <= period_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_coil_r    <= coil_of(phase_r);
      o_step_r    <= step_r;
      o_period_r  <= period_r;
      o_running_r <= active_r;
      o_pos_r     <= pos_r;
      o_rate_r    <= rate_now_r;
      o_limit_r   <= limit_r;
    end
  end

  assign out_coil    = o_coil_r;
  assign out_step    = o_step_r;
  assign out_period  = o_period_r;
  assign out_running = o_running_r;
  assign out_pos     = o_pos_r;
  assign out_rate    = o_rate_r;
  assign out_limit   = o_limit_r;

endmodule

// ===== hdl/shrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// shrc_ctrl
// Sequencer: accept, ramp increment, ramp, period divide, emit; owns the
// item handshake.
// ----------------------------------------------------------------------------
module shrc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  shrc_pkg::shrc_status_t status,
  output shrc_pkg::shrc_cmd_t    cmd
);
  import shrc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INC     = 3'd1;
  localparam logic [2:0] S_RATE    = 3'd2;
  localparam logic [2:0] S_DIV_PER = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;
  localparam logic [2:0] S_RAMP    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.need_ramp) begin
            cmd.start_inc = 1'b1;
            state_nxt     = S_INC;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_INC: begin
        cmd.load_inc = 1'b1;
        state_nxt    = S_RAMP;
      end
      S_RAMP: begin
        cmd.ramp  = 1'b1;
        state_nxt = S_RATE;
      end
      S_RATE: begin
        if (status.rate_zero) begin
          cmd.set_idle = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.start_per = 1'b1;
          state_nxt     = S_DIV_PER;
        end
      end
      S_DIV_PER: begin
        if (status.div_done) begin
          cmd.set_period = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
